@@ rtl/rgbhsi_pkg.sv @@
// Package for the RGB to HSI pixel core: widths, CORDIC angle table.
// No dependencies.
package rgbhsi_pkg;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int CORDIC_STEPS   = 24;
  localparam int XY_W           = 30;   // |x|,|y| < 2^28 growth-safe
  localparam int Z_W            = 34;
  localparam int SUM_W          = 10;
  localparam int SQRT3_Q16      = 113512;

  function automatic logic [31:0] atan_turn(input int i);
    case (i)
      0: atan_turn = 32'd536870912;  1: atan_turn = 32'd316933406;
      2: atan_turn = 32'd167458907;  3: atan_turn = 32'd85004756;
      4: atan_turn = 32'd42667331;   5: atan_turn = 32'd21354465;
      6: atan_turn = 32'd10679838;   7: atan_turn = 32'd5340245;
      8: atan_turn = 32'd2670163;    9: atan_turn = 32'd1335087;
      10: atan_turn = 32'd667544;    11: atan_turn = 32'd333772;
      12: atan_turn = 32'd166886;    13: atan_turn = 32'd83443;
      14: atan_turn = 32'd41722;     15: atan_turn = 32'd20861;
      16: atan_turn = 32'd10430;     17: atan_turn = 32'd5215;
      18: atan_turn = 32'd2608;      19: atan_turn = 32'd1304;
      20: atan_turn = 32'd652;       21: atan_turn = 32'd326;
      22: atan_turn = 32'd163;       23: atan_turn = 32'd81;
      default: atan_turn = 32'd0;
    endcase
  endfunction
endpackage

@@ rtl/rgb_to_hsi_pixel_core.sv @@
// RGB to HSI pixel core: top level, CORDIC hue pipeline, intensity, saturation.
// Depends on rgbhsi_pkg and rgbhsi_sat_div.
//   channel | ports                              | direction
//   in      | in_valid/in_ready, red/green/blue  | pixel in
//   out     | out_valid/out_ready, hue/sat/inten | result out
// Pipeline: 1 input stage, 24 CORDIC stages (one rotation each, which sets
// the depth), 1 output stage; one pixel per cycle unless stalled. The whole pipe
// advances when the output register is empty or being taken. Reset clears valid bits.
module rgb_to_hsi_pixel_core #(
  parameter int ANGLE_BITS = rgbhsi_pkg::ANGLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_hue_angle,
  output logic [15:0] out_saturation,
  output logic [15:0] out_intensity
);
  import rgbhsi_pkg::*;
  localparam int NS = CORDIC_STEPS;
  localparam int LAT = NS + 1;
  localparam int VL = NS + 2;
  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  logic signed [XY_W-1:0] x_r [NS+1];
  logic signed [XY_W-1:0] y_r [NS+1];
  logic signed [Z_W-1:0]  z_r [NS+1];
  logic [VL-1:0] v_r;
  logic [LAT-1:0] gray_r, bgt_r;
  logic [SUM_W-1:0] sum_r [LAT];
  logic [7:0] mn_r;

  logic [SUM_W-1:0] sum_c;
  logic [7:0] mn_c, d_c;
  logic signed [XY_W-1:0] x_c, y_c;
  always_comb begin
    sum_c = SUM_W'(in_red) + SUM_W'(in_green) + SUM_W'(in_blue);
    mn_c = in_red;
    if (in_green < mn_c) mn_c = in_green;
    if (in_blue < mn_c) mn_c = in_blue;
    d_c = (in_green > in_blue) ? in_green - in_blue : in_blue - in_green;
    x_c = XY_W'($signed({2'b00, in_red, 1'b0}) - $signed({3'b000, in_green})
          - $signed({3'b000, in_blue})) <<< 16;
    y_c = XY_W'($signed({1'b0, d_c}) * $signed(18'(SQRT3_Q16)));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (x_c < 0) begin
        x_r[0] <= y_c;
        y_r[0] <= -x_c;
        z_r[0] <= Z_W'(64'd1073741824);
      end else begin
        x_r[0] <= x_c;
        y_r[0] <= y_c;
        z_r[0] <= '0;
      end
      gray_r[0] <= (in_red == in_green) && (in_green == in_blue);
      bgt_r[0]  <= in_blue > in_green;
      sum_r[0]  <= sum_c;
      mn_r      <= mn_c;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (en) begin
        if (y_r[i] > 0) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + Z_W'(atan_turn(i));
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - Z_W'(atan_turn(i));
        end
        gray_r[i+1] <= gray_r[i];
        bgt_r[i+1]  <= bgt_r[i];
      end
    end
  end
  for (genvar i = 1; i < LAT; i++) begin : g_sum
    always_ff @(posedge clk) if (en) sum_r[i] <= sum_r[i-1];
  end

  logic [15:0] quo;
  logic [7:0] mn_d_r [8];
  // align min with sum stage 8 feeding the divider
  always_ff @(posedge clk) begin
    if (en) begin
      mn_d_r[0] <= mn_r;
      for (int k = 1; k < 8; k++) mn_d_r[k] <= mn_d_r[k-1];
    end
  end
  rgbhsi_sat_div u_div (.clk(clk), .en(en), .sum_i(sum_r[8]), .mn_i(mn_d_r[7]), .quo_o(quo));

  // hue finish
  logic signed [Z_W-1:0] zc;
  logic [Z_W-1:0] zu, zr;
  logic [ANGLE_BITS-1:0] hue_c;
  logic [SUM_W-1:0] sf;
  logic [25:0] inum;
  logic [52:0] iprod;
  logic [15:0] int_c, sat_c;
  always_comb begin
    zc = z_r[NS];
    if (zc < 0) zc = '0;
    if (zc > $signed(Z_W'(64'd2147483648))) zc = Z_W'(64'd2147483648);
    zu = Z_W'(zc);
    if (bgt_r[NS]) zu = Z_W'(64'd4294967296) - zu;
    zr = zu + (Z_W'(1) << (31 - ANGLE_BITS));
    hue_c = zr[31 -: ANGLE_BITS];
    if (gray_r[NS]) hue_c = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
    sf = sum_r[NS];
    // (sum*65536+765)/1530 by reciprocal ceil(2^37/1530), exact for 26-bit numerators
    inum = {sf, 16'd0} + 26'd765;
    iprod = 53'(inum) * 53'(27'd89829382);
    int_c = iprod[52:37];
    sat_c = (sf == '0) ? 16'd32768 : 16'd32768 - quo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[VL-2:0], in_valid};
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_hue_angle  <= 16'(hue_c);
      out_saturation <= sat_c;
      out_intensity  <= int_c;
    end
  end
  assign out_valid = v_r[VL-1];
endmodule

@@ rtl/rgbhsi_sat_div.sv @@
// Pipelined restoring divider for saturation: floor((3*min*65536+sum)/(2*sum)).
// One quotient bit per stage, 16 stages, advances on en. Uses rgbhsi_pkg.
module rgbhsi_sat_div (
  input  logic                           clk,
  input  logic                           en,
  input  logic [rgbhsi_pkg::SUM_W-1:0]   sum_i,
  input  logic [7:0]                     mn_i,
  output logic [15:0]                    quo_o
);
  import rgbhsi_pkg::*;
  localparam int NS = 16;
  localparam int DW = SUM_W + 1;
  localparam int NW = 27;
  logic [NW-1:0] num_r [NS];
  logic [DW-1:0] den_r [NS];
  logic [DW-1:0] rem_r [NS];
  logic [15:0]   q_r   [NS];
  logic [NW-1:0] num0;
  assign num0 = NW'({mn_i, 16'd0}) + NW'({mn_i, 17'd0}) + NW'(sum_i);
  for (genvar k = 0; k < NS; k++) begin : g_st
    logic [NW-1:0] num_in;
    logic [DW-1:0] den_in, rem_in;
    logic [15:0]   q_in;
    logic [DW:0]   t;
    logic          ge;
    if (k == 0) begin : g_head
      // quotient < 2^16 since 3*min <= sum, so the top 11 bits seed the remainder
      assign num_in = num0;
      assign den_in = {sum_i, 1'b0};
      assign rem_in = num0[NW-1:16];
      assign q_in   = '0;
    end else begin : g_body
      assign num_in = num_r[k-1];
      assign den_in = den_r[k-1];
      assign rem_in = rem_r[k-1];
      assign q_in   = q_r[k-1];
    end
    assign t  = {rem_in, num_in[15-k]};
    assign ge = t >= {1'b0, den_in};
    always_ff @(posedge clk) begin
      if (en) begin
        num_r[k] <= num_in;
        den_r[k] <= den_in;
        rem_r[k] <= ge ? DW'(t - {1'b0, den_in}) : DW'(t);
        q_r[k]   <= {q_in[14:0], ge};
      end
    end
  end
  assign quo_o = q_r[NS-1];
endmodule
